FILE: design/bcd_pkg.sv
// ----------------------------------------------------------------------------
// bcd_pkg
// Shared widths, register map and configuration types for the chord detector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bcd_pkg;

    localparam int BUTTON_BITS = 32;
    localparam int TIME_BITS   = 64;
    localparam int COUNT_BITS  = 32;
    localparam int MS_BITS     = 16;
    localparam int DATA_BITS   = 32;
    localparam int ADDR_BITS   = 4;
    localparam int INDEX_BITS  = 2;

    typedef enum logic [INDEX_BITS-1:0] {
        REG_COMBO_MASK = 2'd0,
        REG_WINDOW_MS  = 2'd1,
        REG_REPLAY_MS  = 2'd2
    } bcd_reg_idx_t;

    localparam logic [BUTTON_BITS-1:0] COMBO_MASK_RESET = '0;
    localparam logic [MS_BITS-1:0]     WINDOW_MS_RESET  = MS_BITS'(250);
    localparam logic [MS_BITS-1:0]     REPLAY_MS_RESET  = MS_BITS'(100);

    localparam logic [TIME_BITS-1:0]   TIME_MAX = '1;

    typedef struct packed {
        logic [BUTTON_BITS-1:0] combo_mask;
        logic [MS_BITS-1:0]     window_ms;
        logic [MS_BITS-1:0]     replay_ms;
    } bcd_cfg_t;

endpackage

`default_nettype wire

FILE: design/button_chord_detector_core.sv
// Pipeline: two register stages (input register, then result register).
// One word per cycle sustained when out_stall is low; the state update between
//   the two registers sets the throughput.
// Reset: rst_n asynchronous, active low; clears all tracking state, the chord
//   count and both pipeline valids; registers return to 0 / 250 / 100.
// ----------------------------------------------------------------------------
// button_chord_detector_core
// Filters button samples: suppresses a full chord, withholds lone chord
// buttons for a window and replays short taps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module button_chord_detector_core
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [bcd_pkg::ADDR_BITS-1:0]   paddr,
    input  wire logic [bcd_pkg::DATA_BITS-1:0]   pwdata,
    output logic      [bcd_pkg::DATA_BITS-1:0]   prdata,
    output logic                                 pready,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [bcd_pkg::BUTTON_BITS-1:0] button_bits,
    input  wire logic [bcd_pkg::TIME_BITS-1:0]   time_now,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic      [bcd_pkg::BUTTON_BITS-1:0] filtered_bits,
    output logic                                 chord_down,
    output logic      [bcd_pkg::COUNT_BITS-1:0]  chord_total
);
    import bcd_pkg::*;

    bcd_cfg_t cfg;

    // input register
    logic                   s1_valid_reg, s1_valid_next;
    logic [BUTTON_BITS-1:0] s1_buttons_reg;
    logic [TIME_BITS-1:0]   s1_time_reg;

    // result register
    logic                   out_valid_reg, out_valid_next;
    logic [BUTTON_BITS-1:0] out_bits_reg, out_bits_next;
    logic                   out_chord_reg, out_chord_next;
    logic [COUNT_BITS-1:0]  out_total_reg, out_total_next;

    // tracking state
    logic                   held_reg, held_next;
    logic                   swallow_reg, swallow_next;
    logic                   pending_reg, pending_next;
    logic [TIME_BITS-1:0]   start_reg, start_next;
    logic [BUTTON_BITS-1:0] withheld_reg, withheld_next;
    logic [BUTTON_BITS-1:0] replay_reg, replay_next;
    logic [TIME_BITS-1:0]   end_reg, end_next;
    logic [COUNT_BITS-1:0]  count_reg, count_next;

    logic                   accept, advance, consume;
    logic [BUTTON_BITS-1:0] down, suppress, result;
    logic [TIME_BITS-1:0]   start_eff, elapsed;
    logic                   in_window, replay_fresh, replay_live;
    logic [TIME_BITS:0]     end_sum;
    logic [TIME_BITS-1:0]   end_sat;

    bcd_cfg_regs u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign advance  = !out_valid_reg || !out_stall;
    assign consume  = s1_valid_reg && advance;
    assign in_stall = s1_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    assign s1_valid_next  = accept ? 1'b1 : (consume ? 1'b0 : s1_valid_reg);
    assign out_valid_next = advance ? s1_valid_reg : out_valid_reg;

    assign down      = s1_buttons_reg & cfg.combo_mask;
    assign start_eff = pending_reg ? start_reg : s1_time_reg;
    assign elapsed   = s1_time_reg - start_eff;
    assign in_window = elapsed < TIME_BITS'(cfg.window_ms);
    assign end_sum   = {1'b0, s1_time_reg} + (TIME_BITS + 1)'(cfg.replay_ms);
    assign end_sat   = end_sum[TIME_BITS] ? TIME_MAX : end_sum[TIME_BITS-1:0];

    always_comb
    begin
        held_next     = held_reg;
        swallow_next  = swallow_reg;
        pending_next  = pending_reg;
        start_next    = start_reg;
        replay_next   = replay_reg;
        end_next      = end_reg;
        count_next    = count_reg;
        suppress      = '0;
        replay_fresh  = 1'b0;

        if (down == cfg.combo_mask)
        begin
            if (!held_reg)
            begin
                count_next = count_reg + 1'b1;
            end
            held_next    = 1'b1;
            swallow_next = 1'b1;
            suppress     = cfg.combo_mask;
            pending_next = 1'b0;
            replay_next  = '0;
        end
        else if (swallow_reg)
        begin
            held_next    = 1'b0;
            suppress     = down;
            pending_next = 1'b0;
            if (down == '0)
            begin
                swallow_next = 1'b0;
            end
        end
        else
        begin
            held_next = 1'b0;
            if (down != '0)
            begin
                pending_next = 1'b1;
                start_next   = start_eff;
                if (in_window)
                begin
                    suppress = down;
                end
                else
                begin
                    pending_next = 1'b0;
                end
            end
            else
            begin
                if (pending_reg && in_window)
                begin
                    replay_next  = withheld_reg;
                    end_next     = end_sat;
                    replay_fresh = 1'b1;
                end
                pending_next = 1'b0;
            end
        end

        withheld_next = suppress;

        // a fresh end time is live unless the replay time is zero or now is the max
        replay_live = replay_fresh
                      ? ((cfg.replay_ms != '0) && (s1_time_reg != TIME_MAX))
                      : (s1_time_reg < end_reg);

        result = s1_buttons_reg & ~suppress;
        if (replay_next != '0)
        begin
            if (replay_live)
            begin
                result = result | replay_next;
            end
            else
            begin
                replay_next = '0;
            end
        end

        out_bits_next  = result;
        out_chord_next = held_next;
        out_total_next = count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            held_reg      <= 1'b0;
            swallow_reg   <= 1'b0;
            pending_reg   <= 1'b0;
            start_reg     <= '0;
            withheld_reg  <= '0;
            replay_reg    <= '0;
            end_reg       <= '0;
            count_reg     <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (consume)
            begin
                held_reg     <= held_next;
                swallow_reg  <= swallow_next;
                pending_reg  <= pending_next;
                start_reg    <= start_next;
                withheld_reg <= withheld_next;
                replay_reg   <= replay_next;
                end_reg      <= end_next;
                count_reg    <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_buttons_reg <= button_bits;
            s1_time_reg    <= time_now;
        end
        if (consume)
        begin
            out_bits_reg  <= out_bits_next;
            out_chord_reg <= out_chord_next;
            out_total_reg <= out_total_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign filtered_bits = out_bits_reg;
    assign chord_down    = out_chord_reg;
    assign chord_total   = out_total_reg;

`ifndef ASSERT_OFF
    a_held_implies_swallow: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg |-> swallow_reg)
        else $error("chord held without swallow latch");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == $past(count_reg)) || (count_reg == $past(count_reg) + 1'b1))
        else $error("chord count jumped");

    a_chord_suppressed: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && chord_down) |-> ((filtered_bits & cfg.combo_mask) == '0))
        else $error("chord buttons leaked while chord held");

    a_empty_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> !in_stall)
        else $error("stall with empty input register");
`endif

endmodule

`default_nettype wire

FILE: design/bcd_cfg_regs.sv
// ----------------------------------------------------------------------------
// bcd_cfg_regs
// APB register bank holding chord mask, hold window and replay time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bcd_cfg_regs
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [bcd_pkg::ADDR_BITS-1:0] paddr,
    input  wire logic [bcd_pkg::DATA_BITS-1:0] pwdata,
    output logic      [bcd_pkg::DATA_BITS-1:0] prdata,
    output logic                               pready,
    output bcd_pkg::bcd_cfg_t                  cfg
);
    import bcd_pkg::*;

    bcd_cfg_t cfg_reg;
    bcd_cfg_t cfg_next;
    logic     wr_en;
    logic [INDEX_BITS-1:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[ADDR_BITS-1:2];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_COMBO_MASK: cfg_next.combo_mask = pwdata[BUTTON_BITS-1:0];
                REG_WINDOW_MS:  cfg_next.window_ms  = pwdata[MS_BITS-1:0];
                REG_REPLAY_MS:  cfg_next.replay_ms  = pwdata[MS_BITS-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_COMBO_MASK: prdata = DATA_BITS'(cfg_reg.combo_mask);
            REG_WINDOW_MS:  prdata = DATA_BITS'(cfg_reg.window_ms);
            REG_REPLAY_MS:  prdata = DATA_BITS'(cfg_reg.replay_ms);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.combo_mask <= COMBO_MASK_RESET;
            cfg_reg.window_ms  <= WINDOW_MS_RESET;
            cfg_reg.replay_ms  <= REPLAY_MS_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire
